FILE: sv/kdhc_pkg.sv
// ----------------------------------------------------------------------------
// kdhc_pkg
// Types, register map and event codes of the key debounce and hold classifier.
// ----------------------------------------------------------------------------
package kdhc_pkg;

    localparam int unsigned DEB_W  = 8;
    localparam int unsigned HOLD_W = 16;
    localparam int unsigned KEYS_W = 2;
    localparam int unsigned KIND_W = 2;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 4;

    // Register indexes (byte address is 4 * index).
    localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
    localparam logic [1:0] REG_SHORT_HOLD = 2'd1;
    localparam logic [1:0] REG_LONG_HOLD  = 2'd2;

    localparam logic [DEB_W-1:0]  DEBOUNCE_RESET   = 8'd3;
    localparam logic [HOLD_W-1:0] SHORT_HOLD_RESET = 16'd150;
    localparam logic [HOLD_W-1:0] LONG_HOLD_RESET  = 16'd500;

    // Event kinds.
    localparam logic [KIND_W-1:0] KIND_PLAIN = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SHORT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LONG  = 2'd2;

    // Bit of the move key in a key pattern.
    localparam int unsigned MOVE_KEY = 1;

    typedef struct packed {
        logic [KEYS_W-1:0] keys_raw;
        logic              cancel_active;
        logic              cancel_timeout;
    } tick_t;

    typedef struct packed {
        logic              key_event;
        logic [KEYS_W-1:0] event_keys;
        logic [KIND_W-1:0] event_kind;
        logic              pending_dropped;
        logic              cancel_released;
        logic              move_hold_pulse;
        logic              test_indicator;
    } result_t;

    typedef struct packed {
        logic [DEB_W-1:0]  debounce_ticks;
        logic [HOLD_W-1:0] short_hold_ticks;
        logic [HOLD_W-1:0] long_hold_ticks;
    } cfg_t;

    typedef struct packed {
        logic              cand_valid;
        logic [KEYS_W-1:0] cand_keys;
        logic [KEYS_W-1:0] stable_keys;
        logic [DEB_W-1:0]  debounce_left;
        logic [HOLD_W-1:0] short_left;
        logic [HOLD_W-1:0] long_left;
        logic              indicator_on;
    } state_t;

endpackage

FILE: sv/kdhc_stream_if.sv
// ----------------------------------------------------------------------------
// kdhc_stream_if
// Valid/ready channel carrying one payload of type T per request.
// ----------------------------------------------------------------------------
interface kdhc_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/kdhc_cfg_regs.sv
// ----------------------------------------------------------------------------
// kdhc_cfg_regs
// APB register file: debounce count and short/long hold counts.
// ----------------------------------------------------------------------------
module kdhc_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [kdhc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [kdhc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [kdhc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    output kdhc_pkg::cfg_t                     cfg
);

    kdhc_pkg::cfg_t cfg_reg;
    kdhc_pkg::cfg_t cfg_next;
    logic           wr_en;
    logic [1:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                kdhc_pkg::REG_DEBOUNCE:
                    cfg_next.debounce_ticks = pwdata[kdhc_pkg::DEB_W-1:0];
                kdhc_pkg::REG_SHORT_HOLD:
                    cfg_next.short_hold_ticks = pwdata[kdhc_pkg::HOLD_W-1:0];
                kdhc_pkg::REG_LONG_HOLD:
                    cfg_next.long_hold_ticks = pwdata[kdhc_pkg::HOLD_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            kdhc_pkg::REG_DEBOUNCE:
                prdata = {{(kdhc_pkg::APB_DATA_W-kdhc_pkg::DEB_W){1'b0}},
                          cfg_reg.debounce_ticks};
            kdhc_pkg::REG_SHORT_HOLD:
                prdata = {{(kdhc_pkg::APB_DATA_W-kdhc_pkg::HOLD_W){1'b0}},
                          cfg_reg.short_hold_ticks};
            kdhc_pkg::REG_LONG_HOLD:
                prdata = {{(kdhc_pkg::APB_DATA_W-kdhc_pkg::HOLD_W){1'b0}},
                          cfg_reg.long_hold_ticks};
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks   <= kdhc_pkg::DEBOUNCE_RESET;
            cfg_reg.short_hold_ticks <= kdhc_pkg::SHORT_HOLD_RESET;
            cfg_reg.long_hold_ticks  <= kdhc_pkg::LONG_HOLD_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: sv/kdhc_step.sv
// ----------------------------------------------------------------------------
// kdhc_step
// One-tick update: debounce, hold countdown and event classification.
// ----------------------------------------------------------------------------
module kdhc_step (
    input  kdhc_pkg::state_t  st,
    input  kdhc_pkg::cfg_t    cfg,
    input  kdhc_pkg::tick_t   tick,
    output kdhc_pkg::state_t  st_next,
    output kdhc_pkg::result_t res
);

    logic [kdhc_pkg::DEB_W-1:0]  deb_dec;
    logic [kdhc_pkg::HOLD_W-1:0] short_dec;
    logic [kdhc_pkg::HOLD_W-1:0] long_dec;
    logic                        same_cand;

    assign deb_dec   = (st.debounce_left != '0) ? st.debounce_left - 1'b1 : '0;
    assign short_dec = st.short_left - 1'b1;
    assign long_dec  = st.long_left - 1'b1;
    assign same_cand = st.cand_valid && (tick.keys_raw == st.cand_keys);

    always_comb
    begin
        st_next = st;
        res     = '0;
        if (tick.cancel_active)
        begin
            // Resync on raw keys, drop anything pending.
            res.cancel_released = tick.cancel_timeout;
            res.pending_dropped = 1'b1;
            st_next.cand_valid    = 1'b1;
            st_next.cand_keys     = tick.keys_raw;
            st_next.stable_keys   = tick.keys_raw;
            st_next.debounce_left = '0;
            st_next.short_left    = '0;
            st_next.long_left     = '0;
        end
        else if (same_cand)
        begin
            st_next.debounce_left = deb_dec;
            if (deb_dec == '0)
            begin
                if (tick.keys_raw != st.stable_keys)
                begin
                    if (tick.keys_raw == '0)
                    begin
                        if (st.long_left != '0)
                        begin
                            res.key_event  = 1'b1;
                            res.event_keys = st.stable_keys;
                            res.event_kind = (st.short_left != '0) ?
                                             kdhc_pkg::KIND_PLAIN : kdhc_pkg::KIND_SHORT;
                        end
                        st_next.short_left = '0;
                        st_next.long_left  = '0;
                    end
                    else
                    begin
                        // New press: reload both hold counters.
                        st_next.short_left = cfg.short_hold_ticks;
                        st_next.long_left  = cfg.long_hold_ticks;
                    end
                end
                else
                begin
                    if (st.short_left != '0)
                    begin
                        st_next.short_left = short_dec;
                        if (short_dec == '0 && tick.keys_raw[kdhc_pkg::MOVE_KEY])
                        begin
                            st_next.indicator_on = 1'b1;
                            res.move_hold_pulse  = 1'b1;
                        end
                    end
                    if (st.long_left != '0)
                    begin
                        st_next.long_left = long_dec;
                        if (long_dec == '0)
                        begin
                            st_next.indicator_on = 1'b0;
                            res.key_event        = 1'b1;
                            res.event_keys       = tick.keys_raw;
                            res.event_kind       = kdhc_pkg::KIND_LONG;
                        end
                    end
                end
                st_next.stable_keys = tick.keys_raw;
            end
        end
        else
        begin
            // Pattern changed: restart the debounce window.
            st_next.cand_valid    = 1'b1;
            st_next.cand_keys     = tick.keys_raw;
            st_next.debounce_left = cfg.debounce_ticks;
        end
        res.test_indicator = st_next.indicator_on;
    end

endmodule

FILE: sv/key_debounce_hold_classifier_core.sv
// ----------------------------------------------------------------------------
// key_debounce_hold_classifier_core
// Two-key debouncer with short/long hold classification and cancel handling.
// ----------------------------------------------------------------------------
// Usage:
//   tick   : sink channel, one request per key sample tick (raw key levels,
//            cancel condition and cancel timeout).
//   result : source channel, exactly one result request per tick: classified
//            key event, cancel status, move hold pulse and indicator state.
//   APB    : debounce_ticks at 0x0, short_hold_ticks at 0x4, long_hold_ticks
//            at 0x8; write only while no tick is in flight.
// Pipeline: an accepted tick is held in the input register, then the state
//   update feeds the result register, which offers it on result.
// Throughput: one tick per cycle unless result stalls; per tick, a debounce
//   compare and two 16-bit decrements lie between input and result registers.
// Reset: clears both pipeline valids, the key/counter state and the
//   indicator; registers return to 3 / 150 / 500.
// Stall: while result.ready is low the result register holds, the input
//   register still takes one more tick, then tick.ready drops until space
//   opens. No request is lost or repeated.
// ----------------------------------------------------------------------------
module key_debounce_hold_classifier_core (
    input  logic                               clk,
    input  logic                               rst_n,
    kdhc_stream_if.sink                        tick,
    kdhc_stream_if.source                      result,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [kdhc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [kdhc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [kdhc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);

    kdhc_pkg::cfg_t    cfg;

    // Input stage
    logic              in_vld_reg;
    logic              in_vld_next;
    kdhc_pkg::tick_t   in_data_reg;

    // Classifier state
    kdhc_pkg::state_t  st_reg;
    kdhc_pkg::state_t  st_next;
    kdhc_pkg::result_t step_res;

    // Result stage
    logic              out_vld_reg;
    logic              out_vld_next;
    kdhc_pkg::result_t out_data_reg;

    logic              advance;
    logic              take_tick;

    kdhc_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    kdhc_step u_step (
        .st      (st_reg),
        .cfg     (cfg),
        .tick    (in_data_reg),
        .st_next (st_next),
        .res     (step_res)
    );

    // Advance the held tick into the result register when that slot is free
    // or being drained this cycle; the state commits on the same edge.
    assign advance   = in_vld_reg && (!out_vld_reg || result.ready);
    assign tick.ready = !in_vld_reg || advance;
    assign take_tick = tick.valid && tick.ready;

    assign in_vld_next  = take_tick ? 1'b1 : (advance ? 1'b0 : in_vld_reg);
    assign out_vld_next = advance ? 1'b1 : ((out_vld_reg && result.ready) ? 1'b0 : out_vld_reg);

    assign result.valid = out_vld_reg;
    assign result.data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            st_reg      <= '0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (advance)
            begin
                st_reg <= st_next;
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        if (take_tick)
        begin
            in_data_reg <= tick.data;
        end
        if (advance)
        begin
            out_data_reg <= step_res;
        end
    end

endmodule
